// ----- src/oahm_pkg.sv -----
// Shared types and codes for the open addressing hash map.
`default_nettype none
package oahm_pkg;
	localparam int KEY_W = 64;
	localparam int VAL_W = 64;
	localparam int HASH_W = 32;
	localparam int OP_W = 2;
	localparam int LIMIT_W = 8;
	localparam int USED_W = LIMIT_W + 1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd192;

	typedef enum logic [1:0] {
		OP_GET = 2'd0,
		OP_SET = 2'd1,
		OP_DEL = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_FULL  = 2'd1,
		KIND_TOMB  = 2'd2,
		KIND_RSVD  = 2'd3
	} kind_t;
endpackage
`default_nettype wire

// ----- src/oahm_slot_store.sv -----
// Slot memories: kind with a clearing sweep, key and value.
`default_nettype none
module oahm_slot_store #(
	parameter int SLOTS = 256,
	parameter int IDX_W = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IDX_W-1:0]      rd_idx,
	output logic [1:0]                 rd_kind,
	output logic [oahm_pkg::KEY_W-1:0] rd_key,
	output logic [oahm_pkg::VAL_W-1:0] rd_val,
	input  wire logic                  wr_en,
	input  wire logic [IDX_W-1:0]      wr_idx,
	input  wire logic [1:0]            wr_kind,
	input  wire logic                  wr_kv,
	input  wire logic [oahm_pkg::KEY_W-1:0] wr_key,
	input  wire logic [oahm_pkg::VAL_W-1:0] wr_val,
	output logic                       clear_busy
);
	import oahm_pkg::*;

	logic [1:0]       kind_mem [SLOTS];
	logic [KEY_W-1:0] key_mem  [SLOTS];
	logic [VAL_W-1:0] val_mem  [SLOTS];
	logic [IDX_W:0]   clr_cnt_q;

	assign clear_busy = !clr_cnt_q[IDX_W];

	// clearing sweep after reset sets every kind to empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clear_busy) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clear_busy) begin
			kind_mem[clr_cnt_q[IDX_W-1:0]] <= KIND_EMPTY;
		end else if (wr_en) begin
			kind_mem[wr_idx] <= wr_kind;
		end
		if (wr_en && wr_kv) begin
			key_mem[wr_idx] <= wr_key;
		end
		if (wr_en) begin
			val_mem[wr_idx] <= wr_val;
		end
		rd_kind <= kind_mem[rd_idx];
		rd_key  <= key_mem[rd_idx];
		rd_val  <= val_mem[rd_idx];
	end
endmodule
`default_nettype wire

// ----- src/open_addressing_hash_map.sv -----
// Top level of the open addressing hash map.
// Every probe step is one read of the slot memories (registered) and one compare;
// a result is written back in the final step. After reset a clearing sweep empties
// the table, during which no request is taken. The result sits in an output register;
// requests are taken one at a time.
`default_nettype none
module open_addressing_hash_map #(
	parameter int SLOTS = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [oahm_pkg::OP_W-1:0]       opcode,
	input  wire logic [oahm_pkg::KEY_W-1:0]      key,
	input  wire logic [oahm_pkg::HASH_W-1:0]     key_hash,
	input  wire logic [oahm_pkg::VAL_W-1:0]      write_value,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 hit,
	output logic [oahm_pkg::VAL_W-1:0]           read_value,
	output logic                                 status,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [oahm_pkg::LIMIT_W-1:0]    cfg_data
);
	import oahm_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = IDX_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_CHECK = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    wval_q;
	logic [IDX_W-1:0]    at_q;
	logic [CNT_W-1:0]    steps_q;
	logic                tomb_seen_q;
	logic [IDX_W-1:0]    tomb_at_q;
	logic [USED_W-1:0]   used_q;
	logic [LIMIT_W-1:0]  limit_q;

	logic [1:0]          rd_kind;
	logic [KEY_W-1:0]    rd_key;
	logic [VAL_W-1:0]    rd_val;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic [1:0]          wr_kind;
	logic                wr_kv;
	logic [VAL_W-1:0]    wr_val;
	logic                clear_busy;

	logic                in_acc;
	logic                slot_free, is_full_match, last_step, finish;
	logic                room;
	logic                tomb_any;
	logic [IDX_W-1:0]    tomb_idx;

	assign in_stall  = (state_q != ST_IDLE) || out_valid || clear_busy;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	oahm_slot_store #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_store (
		.clk(clk), .arst_n(arst_n), .rd_idx(at_q),
		.rd_kind(rd_kind), .rd_key(rd_key), .rd_val(rd_val),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_kind(wr_kind), .wr_kv(wr_kv),
		.wr_key(key_q), .wr_val(wr_val), .clear_busy(clear_busy)
	);

	assign slot_free     = rd_kind == KIND_EMPTY;
	assign is_full_match = (rd_kind == KIND_FULL) && (rd_key == key_q);
	assign last_step     = steps_q == CNT_W'(SLOTS - 1);
	assign finish        = (state_q == ST_CHECK) && (slot_free || is_full_match || last_step);
	assign room          = {1'b0, used_q} + 1'b1 <= {{(USED_W+1-LIMIT_W){1'b0}}, limit_q};
	// a tombstone in the last slot of a full-length probe still counts
	assign tomb_any      = tomb_seen_q || (rd_kind == KIND_TOMB);
	assign tomb_idx      = tomb_seen_q ? tomb_at_q : at_q;

	// write-back decision at the end of the probe
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = at_q;
		wr_kind = KIND_FULL;
		wr_kv   = 1'b0;
		wr_val  = wval_q;
		if (finish) begin
			case (op_q)
				OP_SET: begin
					if (is_full_match) begin
						wr_en = 1'b1;
					end else if (tomb_any) begin
						wr_en  = 1'b1;
						wr_kv  = 1'b1;
						wr_idx = tomb_idx;
					end else if (slot_free && room) begin
						wr_en = 1'b1;
						wr_kv = 1'b1;
					end
				end
				OP_DEL: begin
					if (is_full_match) begin
						wr_en   = 1'b1;
						wr_kind = KIND_TOMB;
						wr_val  = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			used_q    <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (opcode == OP_NOP) ? ST_DONE : ST_READ;
					end
				end
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (finish) begin
						state_q <= ST_DONE;
						if (op_q == OP_SET && !is_full_match && !tomb_any
								&& slot_free && room) begin
							used_q <= used_q + 1'b1;
						end
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					state_q   <= ST_IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q        <= opcode;
			key_q       <= key;
			wval_q      <= write_value;
			at_q        <= key_hash[IDX_W-1:0];
			steps_q     <= '0;
			tomb_seen_q <= 1'b0;
			hit         <= 1'b0;
			read_value  <= '0;
			status      <= 1'b0;
		end
		if (state_q == ST_CHECK) begin
			if (finish) begin
				case (op_q)
					OP_GET: begin
						hit        <= is_full_match;
						read_value <= is_full_match ? rd_val : '0;
					end
					OP_SET: begin
						hit    <= !is_full_match && (tomb_any || (slot_free && room));
						status <= !is_full_match && !tomb_any && !(slot_free && room);
					end
					OP_DEL: hit <= is_full_match;
					default: ;
				endcase
			end else begin
				if (rd_kind == KIND_TOMB && !tomb_seen_q) begin
					tomb_seen_q <= 1'b1;
					tomb_at_q   <= at_q;
				end
				at_q    <= at_q + 1'b1;
				steps_q <= steps_q + 1'b1;
			end
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= {1'b0, {LIMIT_W{1'b1}}}) else $error("used count out of range");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_CHECK) else $error("slot write outside probe");
	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE) else $error("result without request");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> in_stall) else $error("request taken during clear");
endmodule
`default_nettype wire
